// ===== rtl/core/ppd_pkg.sv =====
package ppd_pkg;

   // Field widths
   localparam int unsigned COORD_W  = 32;
   localparam int unsigned INDEX_W  = 16;
   localparam int unsigned THRESH_W = 31;
   localparam int unsigned PROD_W   = 2 * COORD_W;
   // Product after the arithmetic shift by 16
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned TERM_W   = PROD_W - FRAC_W;
   // Sum of three terms and the offset
   localparam int unsigned SUM_W    = TERM_W + 2;
   // Coordinate minus correction
   localparam int unsigned DIFF_W   = TERM_W + 1;

   // Register map, word index within the port
   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [2:0] REG_COEF_A    = 3'd0;
   localparam logic [2:0] REG_COEF_B    = 3'd1;
   localparam logic [2:0] REG_COEF_C    = 3'd2;
   localparam logic [2:0] REG_COEF_D    = 3'd3;
   localparam logic [2:0] REG_THRESHOLD = 3'd4;

   // Register reset values
   localparam logic [COORD_W-1:0]  COEF_A_RESET    = 32'h0000_0000;
   localparam logic [COORD_W-1:0]  COEF_B_RESET    = 32'h0000_0000;
   localparam logic [COORD_W-1:0]  COEF_C_RESET    = 32'h0001_0000;
   localparam logic [COORD_W-1:0]  COEF_D_RESET    = 32'h0000_0000;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 31'h0000_0000;

   localparam logic [COORD_W-1:0]  S32_MAX = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0]  S32_MIN = 32'h8000_0000;
   localparam logic [THRESH_W-1:0] U31_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [COORD_W-1:0]  coef_a;
      logic [COORD_W-1:0]  coef_b;
      logic [COORD_W-1:0]  coef_c;
      logic [COORD_W-1:0]  coef_d;
      logic [THRESH_W-1:0] distance_threshold;
   } plane_cfg_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } point_type;

   // Scored point on its way to the projection stages
   typedef struct packed {
      point_type           pt;
      logic [COORD_W-1:0]  sd;
      logic [THRESH_W-1:0] abs_distance;
      logic                is_inlier;
      logic                is_outlier;
   } score_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  index_out;
      logic [THRESH_W-1:0] abs_distance;
      logic                is_inlier;
      logic                is_outlier;
      logic [COORD_W-1:0]  proj_x;
      logic [COORD_W-1:0]  proj_y;
      logic [COORD_W-1:0]  proj_z;
   } result_type;

   // Clamp a wide signed value to the signed 32-bit range
   function automatic logic [COORD_W-1:0] sat32(input logic [SUM_W-1:0] v);
      logic [COORD_W-1:0] r;
      if (v[SUM_W-1:COORD_W-1] == {(SUM_W-COORD_W+1){v[SUM_W-1]}}) begin
         r = v[COORD_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = S32_MIN;
      end else begin
         r = S32_MAX;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/point_plane_distance_project.sv =====
// Five register stages lie between an accepted request beat and its response beat.
// Throughput: one point per cycle while the response is not stalled; each of the five stages holds one beat,
// and a stalled response only holds the stages that are full.
// Reset clears all stage valid bits and loads the plane registers with
// a = b = d = 0, c = 1.0 and a zero threshold.
module point_plane_distance_project (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [31:0]                    req_point_x,
   input  logic [31:0]                    req_point_y,
   input  logic [31:0]                    req_point_z,
   input  logic [15:0]                    req_point_index,
   // Response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [15:0]                    rsp_index_out,
   output logic [30:0]                    rsp_abs_distance,
   output logic                           rsp_is_inlier,
   output logic                           rsp_is_outlier,
   output logic [31:0]                    rsp_proj_x,
   output logic [31:0]                    rsp_proj_y,
   output logic [31:0]                    rsp_proj_z,
   // Register port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ppd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   ppd_pkg::plane_cfg_type cfg;
   ppd_pkg::point_type     point;
   ppd_pkg::score_type     score;
   ppd_pkg::result_type    result;
   logic                   score_valid;
   logic                   score_ready;

   assign point.index = req_point_index;
   assign point.x     = req_point_x;
   assign point.y     = req_point_y;
   assign point.z     = req_point_z;

   ppd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ppd_score u_score (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_point  (point),
      .out_valid (score_valid),
      .out_ready (score_ready),
      .out_score (score)
   );

   ppd_project u_project (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (score_valid),
      .in_ready   (score_ready),
      .in_score   (score),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (result)
   );

   assign rsp_index_out    = result.index_out;
   assign rsp_abs_distance = result.abs_distance;
   assign rsp_is_inlier    = result.is_inlier;
   assign rsp_is_outlier   = result.is_outlier;
   assign rsp_proj_x       = result.proj_x;
   assign rsp_proj_y       = result.proj_y;
   assign rsp_proj_z       = result.proj_z;

endmodule

// ===== rtl/core/ppd_csr.sv =====
module ppd_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [ppd_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [31:0]                            csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready,
   output ppd_pkg::plane_cfg_type                 cfg
);

   ppd_pkg::plane_cfg_type cfg_ff;
   logic                   wr_en;
   logic [2:0]             reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   // Write the addressed register on the access phase; drop unknown addresses
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_a             <= ppd_pkg::COEF_A_RESET;
         cfg_ff.coef_b             <= ppd_pkg::COEF_B_RESET;
         cfg_ff.coef_c             <= ppd_pkg::COEF_C_RESET;
         cfg_ff.coef_d             <= ppd_pkg::COEF_D_RESET;
         cfg_ff.distance_threshold <= ppd_pkg::THRESHOLD_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            ppd_pkg::REG_COEF_A: cfg_ff.coef_a <= csr_pwdata;
            ppd_pkg::REG_COEF_B: cfg_ff.coef_b <= csr_pwdata;
            ppd_pkg::REG_COEF_C: cfg_ff.coef_c <= csr_pwdata;
            ppd_pkg::REG_COEF_D: cfg_ff.coef_d <= csr_pwdata;
            ppd_pkg::REG_THRESHOLD: begin
               cfg_ff.distance_threshold <= csr_pwdata[ppd_pkg::THRESH_W-1:0];
            end
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      case (reg_sel)
         ppd_pkg::REG_COEF_A:    csr_prdata = cfg_ff.coef_a;
         ppd_pkg::REG_COEF_B:    csr_prdata = cfg_ff.coef_b;
         ppd_pkg::REG_COEF_C:    csr_prdata = cfg_ff.coef_c;
         ppd_pkg::REG_COEF_D:    csr_prdata = cfg_ff.coef_d;
         ppd_pkg::REG_THRESHOLD: csr_prdata = {1'b0, cfg_ff.distance_threshold};
         default:                csr_prdata = '0;
      endcase
   end

endmodule

// ===== rtl/core/ppd_score.sv =====
module ppd_score (
   input  logic                   clock,
   input  logic                   reset,
   input  ppd_pkg::plane_cfg_type cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ppd_pkg::point_type     in_point,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ppd_pkg::score_type     out_score
);

   localparam int unsigned TW = ppd_pkg::TERM_W;
   localparam int unsigned SW = ppd_pkg::SUM_W;
   localparam int unsigned CW = ppd_pkg::COORD_W;

   logic adv1, adv2, adv3;
   logic v1_ff, v2_ff, v3_ff;

   logic signed [ppd_pkg::PROD_W-1:0] prod_a, prod_b, prod_c;
   logic [TW-1:0]             ta1_in, tb1_in, tc1_in;
   logic [TW-1:0]             ta1_ff, tb1_ff, tc1_ff;
   ppd_pkg::point_type        pt1_ff, pt2_ff;
   logic [SW-1:0]             s2_in, s2_ff;
   logic [SW-1:0]             mag;
   ppd_pkg::score_type        sc3_in, sc3_ff;

   // Advance a stage when it is empty or the next one advances
   assign adv3     = !v3_ff || out_ready;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= in_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // Stage 1: form the three products and shift them down by the fraction
   assign prod_a = $signed(cfg.coef_a) * $signed(in_point.x);
   assign prod_b = $signed(cfg.coef_b) * $signed(in_point.y);
   assign prod_c = $signed(cfg.coef_c) * $signed(in_point.z);
   assign ta1_in = prod_a[ppd_pkg::PROD_W-1:ppd_pkg::FRAC_W];
   assign tb1_in = prod_b[ppd_pkg::PROD_W-1:ppd_pkg::FRAC_W];
   assign tc1_in = prod_c[ppd_pkg::PROD_W-1:ppd_pkg::FRAC_W];

   always_ff @(posedge clock) begin
      if (adv1) begin
         pt1_ff <= in_point;
         ta1_ff <= ta1_in;
         tb1_ff <= tb1_in;
         tc1_ff <= tc1_in;
      end
   end

   // Stage 2: sum the terms and the offset into the signed distance
   assign s2_in = {{(SW-TW){ta1_ff[TW-1]}}, ta1_ff}
                + {{(SW-TW){tb1_ff[TW-1]}}, tb1_ff}
                + {{(SW-TW){tc1_ff[TW-1]}}, tc1_ff}
                + {{(SW-CW){cfg.coef_d[CW-1]}}, cfg.coef_d};

   always_ff @(posedge clock) begin
      if (adv2) begin
         pt2_ff <= pt1_ff;
         s2_ff  <= s2_in;
      end
   end

   // Stage 3: magnitude, threshold compares and clamped signed distance
   assign mag = s2_ff[SW-1] ? (~s2_ff + 1'b1) : s2_ff;

   always_comb begin
      sc3_in.pt = pt2_ff;
      sc3_in.sd = ppd_pkg::sat32(s2_ff);
      if (mag > {{(SW-ppd_pkg::THRESH_W){1'b0}}, ppd_pkg::U31_MAX}) begin
         sc3_in.abs_distance = ppd_pkg::U31_MAX;
      end else begin
         sc3_in.abs_distance = mag[ppd_pkg::THRESH_W-1:0];
      end
      sc3_in.is_inlier  =
         mag < {{(SW-ppd_pkg::THRESH_W){1'b0}}, cfg.distance_threshold};
      sc3_in.is_outlier =
         mag > {{(SW-ppd_pkg::THRESH_W){1'b0}}, cfg.distance_threshold};
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         sc3_ff <= sc3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_score = sc3_ff;

endmodule

// ===== rtl/core/ppd_project.sv =====
module ppd_project (
   input  logic                   clock,
   input  logic                   reset,
   input  ppd_pkg::plane_cfg_type cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ppd_pkg::score_type     in_score,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ppd_pkg::result_type    out_result
);

   localparam int unsigned TW = ppd_pkg::TERM_W;
   localparam int unsigned DW = ppd_pkg::DIFF_W;
   localparam int unsigned SW = ppd_pkg::SUM_W;
   localparam int unsigned CW = ppd_pkg::COORD_W;

   logic adv4, adv5;
   logic v4_ff, v5_ff;

   logic signed [ppd_pkg::PROD_W-1:0] corr_a, corr_b, corr_c;
   logic [TW-1:0]             ka4_ff, kb4_ff, kc4_ff;
   ppd_pkg::score_type        sc4_ff;
   logic [DW-1:0]             dx, dy, dz;
   ppd_pkg::result_type       res5_in, res5_ff;

   // Advance a stage when it is empty or the next one advances
   assign adv5     = !v5_ff || out_ready;
   assign adv4     = !v4_ff || adv5;
   assign in_ready = adv4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv4) begin
            v4_ff <= in_valid;
         end
         if (adv5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   // Stage 4: corrections, clamped distance times each normal component
   assign corr_a = $signed(in_score.sd) * $signed(cfg.coef_a);
   assign corr_b = $signed(in_score.sd) * $signed(cfg.coef_b);
   assign corr_c = $signed(in_score.sd) * $signed(cfg.coef_c);

   always_ff @(posedge clock) begin
      if (adv4) begin
         sc4_ff <= in_score;
         ka4_ff <= corr_a[ppd_pkg::PROD_W-1:ppd_pkg::FRAC_W];
         kb4_ff <= corr_b[ppd_pkg::PROD_W-1:ppd_pkg::FRAC_W];
         kc4_ff <= corr_c[ppd_pkg::PROD_W-1:ppd_pkg::FRAC_W];
      end
   end

   // Stage 5: subtract from the coordinates and clamp
   assign dx = {{(DW-CW){sc4_ff.pt.x[CW-1]}}, sc4_ff.pt.x} - {{(DW-TW){ka4_ff[TW-1]}}, ka4_ff};
   assign dy = {{(DW-CW){sc4_ff.pt.y[CW-1]}}, sc4_ff.pt.y} - {{(DW-TW){kb4_ff[TW-1]}}, kb4_ff};
   assign dz = {{(DW-CW){sc4_ff.pt.z[CW-1]}}, sc4_ff.pt.z} - {{(DW-TW){kc4_ff[TW-1]}}, kc4_ff};

   always_comb begin
      res5_in.index_out    = sc4_ff.pt.index;
      res5_in.abs_distance = sc4_ff.abs_distance;
      res5_in.is_inlier    = sc4_ff.is_inlier;
      res5_in.is_outlier   = sc4_ff.is_outlier;
      res5_in.proj_x       = ppd_pkg::sat32({{(SW-DW){dx[DW-1]}}, dx});
      res5_in.proj_y       = ppd_pkg::sat32({{(SW-DW){dy[DW-1]}}, dy});
      res5_in.proj_z       = ppd_pkg::sat32({{(SW-DW){dz[DW-1]}}, dz});
   end

   always_ff @(posedge clock) begin
      if (adv5) begin
         res5_ff <= res5_in;
      end
   end

   assign out_valid  = v5_ff;
   assign out_result = res5_ff;

endmodule

// ===== dv/tb.sv =====
module tb;

   localparam int unsigned LATENCY       = 5;
   localparam int unsigned REG_SLOTS     = 1 << (ppd_pkg::CSR_ADDR_W - 2);
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned PHASE_POINTS  = 150;
   localparam int unsigned HOLD_OFF      = 120;
   localparam longint      WATCHDOG      = 2_000_000;

   localparam logic [31:0] Q_ONE    = 32'h0001_0000;
   localparam logic [31:0] POS_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_MAX  = 32'h8000_0000;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   // How wide the random values spread
   typedef enum int {SPREAD_NEAR, SPREAD_FULL, SPREAD_EXTREME} spread_kind;

   // Plane shadow, distance and projection predictor, and the queue of pending scores
   class plane_ledger;
      ppd_pkg::plane_cfg_type plane;
      ppd_pkg::result_type    expected_scores[$];
      int failures;
      int checked;
      int inliers;
      int outliers;

      function new();
         plane.coef_a             = ppd_pkg::COEF_A_RESET;
         plane.coef_b             = ppd_pkg::COEF_B_RESET;
         plane.coef_c             = ppd_pkg::COEF_C_RESET;
         plane.coef_d             = ppd_pkg::COEF_D_RESET;
         plane.distance_threshold = ppd_pkg::THRESHOLD_RESET;
         failures = 0;
         checked  = 0;
         inliers  = 0;
         outliers = 0;
      endfunction

      static function longint clamp_s32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function void set_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            ppd_pkg::REG_COEF_A:    plane.coef_a = value;
            ppd_pkg::REG_COEF_B:    plane.coef_b = value;
            ppd_pkg::REG_COEF_C:    plane.coef_c = value;
            ppd_pkg::REG_COEF_D:    plane.coef_d = value;
            ppd_pkg::REG_THRESHOLD: plane.distance_threshold = value[30:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] register_value(logic [2:0] idx);
         case (idx)
            ppd_pkg::REG_COEF_A:    return plane.coef_a;
            ppd_pkg::REG_COEF_B:    return plane.coef_b;
            ppd_pkg::REG_COEF_C:    return plane.coef_c;
            ppd_pkg::REG_COEF_D:    return plane.coef_d;
            ppd_pkg::REG_THRESHOLD: return {1'b0, plane.distance_threshold};
            default:                return '0;
         endcase
      endfunction

      function void check_register(logic [2:0] idx, logic [31:0] seen);
         if (seen !== register_value(idx)) begin
            $error("register %0d: expected %08h, got %08h", idx, register_value(idx), seen);
            failures++;
         end
      endfunction

      // Signed distance from truncated products, then the projection from its clamped value
      function ppd_pkg::result_type score_point(ppd_pkg::point_type p);
         ppd_pkg::result_type r;
         longint x, y, z, a, b, c, d, thr, s, mag, sd, px, py, pz;
         x   = longint'($signed(p.x));
         y   = longint'($signed(p.y));
         z   = longint'($signed(p.z));
         a   = longint'($signed(plane.coef_a));
         b   = longint'($signed(plane.coef_b));
         c   = longint'($signed(plane.coef_c));
         d   = longint'($signed(plane.coef_d));
         thr = longint'({1'b0, plane.distance_threshold});
         s   = ((a * x) >>> 16) + ((b * y) >>> 16) + ((c * z) >>> 16) + d;
         mag = (s < 0) ? -s : s;
         sd  = clamp_s32(s);
         px  = clamp_s32(x - ((sd * a) >>> 16));
         py  = clamp_s32(y - ((sd * b) >>> 16));
         pz  = clamp_s32(z - ((sd * c) >>> 16));
         r.index_out    = p.index;
         r.abs_distance = (mag > 64'sd2147483647) ? 31'h7FFF_FFFF : mag[30:0];
         r.is_inlier    = (mag < thr);
         r.is_outlier   = (mag > thr);
         r.proj_x       = px[31:0];
         r.proj_y       = py[31:0];
         r.proj_z       = pz[31:0];
         return r;
      endfunction

      function void note_point(ppd_pkg::point_type p);
         expected_scores.insert(expected_scores.size(), score_point(p));
      endfunction

      function int pending();
         return expected_scores.size();
      endfunction

      function void same_field(string name, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            failures++;
         end
      endfunction

      function void check_result(ppd_pkg::result_type seen);
         ppd_pkg::result_type want;
         if (expected_scores.size() == 0) begin
            $error("response beat with nothing pending, index_out %0h", seen.index_out);
            failures++;
            return;
         end
         want = expected_scores.pop_front();
         same_field("index_out", 32'(want.index_out), 32'(seen.index_out));
         same_field("abs_distance", 32'(want.abs_distance), 32'(seen.abs_distance));
         same_field("is_inlier", 32'(want.is_inlier), 32'(seen.is_inlier));
         same_field("is_outlier", 32'(want.is_outlier), 32'(seen.is_outlier));
         same_field("proj_x", want.proj_x, seen.proj_x);
         same_field("proj_y", want.proj_y, seen.proj_y);
         same_field("proj_z", want.proj_z, seen.proj_z);
         checked++;
         inliers  += int'(seen.is_inlier);
         outliers += int'(seen.is_outlier);
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [31:0]                    req_point_x;
   logic [31:0]                    req_point_y;
   logic [31:0]                    req_point_z;
   logic [15:0]                    req_point_index;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [15:0]                    rsp_index_out;
   logic [30:0]                    rsp_abs_distance;
   logic                           rsp_is_inlier;
   logic                           rsp_is_outlier;
   logic [31:0]                    rsp_proj_x;
   logic [31:0]                    rsp_proj_y;
   logic [31:0]                    rsp_proj_z;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [ppd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                    csr_pwdata;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;

   plane_ledger ledger;
   logic [15:0] ready_pattern = '1;
   logic [3:0]  pattern_pos   = '0;
   int          hold_cycles   = 0;
   int          points_sent   = 0;
   int          planes_set    = 0;

   point_plane_distance_project i_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: check beats at the rising edge, pick the next ready at the falling edge
   initial begin
      ppd_pkg::result_type beat;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            beat.index_out    = rsp_index_out;
            beat.abs_distance = rsp_abs_distance;
            beat.is_inlier    = rsp_is_inlier;
            beat.is_outlier   = rsp_is_outlier;
            beat.proj_x       = rsp_proj_x;
            beat.proj_y       = rsp_proj_y;
            beat.proj_z       = rsp_proj_z;
            ledger.check_result(beat);
         end
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready = ready_pattern[pattern_pos];
            pattern_pos++;
         end
      end
   end

   function automatic logic [ppd_pkg::CSR_ADDR_W-1:0] reg_addr(logic [2:0] idx);
      return {idx, 2'b00};
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = reg_addr(idx);
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      ledger.set_register(idx, data);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic csr_read(logic [2:0] idx);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = reg_addr(idx);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      ledger.check_register(idx, csr_prdata);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic read_back_plane();
      for (int k = int'(ppd_pkg::REG_COEF_A); k <= int'(ppd_pkg::REG_THRESHOLD); k++) begin
         csr_read(3'(k));
      end
   endtask

   task automatic program_plane(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                logic [31:0] d, logic [31:0] thr);
      csr_write(ppd_pkg::REG_COEF_A, a);
      csr_write(ppd_pkg::REG_COEF_B, b);
      csr_write(ppd_pkg::REG_COEF_C, c);
      csr_write(ppd_pkg::REG_COEF_D, d);
      csr_write(ppd_pkg::REG_THRESHOLD, thr);
      read_back_plane();
      planes_set++;
   endtask

   // Hold valid and payload until the beat is taken
   task automatic send_point(ppd_pkg::point_type p);
      @(negedge clock);
      req_valid       = 1'b1;
      req_point_x     = p.x;
      req_point_y     = p.y;
      req_point_z     = p.z;
      req_point_index = p.index;
      do @(posedge clock); while (!req_ready);
      ledger.note_point(p);
      points_sent++;
   endtask

   task automatic send_xyz(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [15:0] idx);
      ppd_pkg::point_type p;
      p.x     = x;
      p.y     = y;
      p.z     = z;
      p.index = idx;
      send_point(p);
   endtask

   task automatic pause_sender(int unsigned cycles);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Drop valid and hold until every pending score has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      do @(posedge clock); while (ledger.pending() != 0);
   endtask

   function automatic logic [31:0] near_value();
      logic [31:0] v;
      v = $urandom;
      return {{11{v[20]}}, v[20:0]};
   endfunction

   function automatic logic [31:0] unit_value();
      logic [31:0] v;
      v = $urandom;
      return {{15{v[16]}}, v[16:0]};
   endfunction

   function automatic logic [31:0] extreme_value();
      case ($urandom_range(0, 6))
         0:       return POS_MAX;
         1:       return NEG_MAX;
         2:       return '0;
         3:       return ALL_ONES;
         4:       return 32'h0000_0001;
         5:       return Q_ONE;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] spread_value(spread_kind k);
      case (k)
         SPREAD_NEAR: return near_value();
         SPREAD_FULL: return $urandom;
         default:     return extreme_value();
      endcase
   endfunction

   function automatic spread_kind pick_spread();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return SPREAD_NEAR;
      if (r < 85) return SPREAD_FULL;
      return SPREAD_EXTREME;
   endfunction

   function automatic ppd_pkg::point_type make_point(spread_kind k);
      ppd_pkg::point_type p;
      p.x     = spread_value(k);
      p.y     = spread_value(k);
      p.z     = spread_value(k);
      p.index = 16'($urandom);
      return p;
   endfunction

   task automatic random_plane(spread_kind k);
      logic [31:0] a, b, c, d, thr;
      case (k)
         SPREAD_NEAR: begin
            a   = unit_value();
            b   = unit_value();
            c   = unit_value();
            d   = near_value();
            thr = $urandom_range(0, 32'h0020_0000);
         end
         SPREAD_FULL: begin
            a   = $urandom;
            b   = $urandom;
            c   = $urandom;
            d   = $urandom;
            thr = $urandom;
         end
         default: begin
            a   = extreme_value();
            b   = extreme_value();
            c   = extreme_value();
            d   = extreme_value();
            thr = extreme_value();
         end
      endcase
      program_plane(a, b, c, d, thr);
   endtask

   // Stream points, either back to back or in bursts with random gaps
   task automatic run_points(int count, bit bursty);
      int burst_left;
      burst_left = $urandom_range(1, 20);
      for (int i = 0; i < count; i++) begin
         if (bursty && burst_left <= 0) begin
            pause_sender($urandom_range(1, 6));
            burst_left = $urandom_range(1, 20);
         end
         send_point(make_point(pick_spread()));
         burst_left--;
      end
   endtask

   initial begin
      ledger          = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_point_x     = '0;
      req_point_y     = '0;
      req_point_z     = '0;
      req_point_index = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset plane is z = 0 with a zero threshold: never an inlier
      read_back_plane();
      send_xyz('0, '0, '0, '0);
      send_xyz(POS_MAX, POS_MAX, POS_MAX, 16'hFFFF);
      send_xyz(NEG_MAX, NEG_MAX, NEG_MAX, 16'h1234);
      send_xyz('0, '0, 32'h0000_0001, 16'h0001);
      send_xyz('0, '0, ALL_ONES, 16'h8000);

      // Extreme coefficients; threshold written with bit 31 set, which is dropped
      wait_drained();
      program_plane(POS_MAX, NEG_MAX, POS_MAX, NEG_MAX, ALL_ONES);
      for (int k = int'(ppd_pkg::REG_THRESHOLD) + 1; k < REG_SLOTS; k++) begin
         csr_write(3'(k), $urandom);
      end
      read_back_plane();
      send_xyz(POS_MAX, NEG_MAX, POS_MAX, 16'h0002);
      send_xyz(NEG_MAX, POS_MAX, NEG_MAX, 16'h0003);
      // distance is the offset alone, one above the saturated limit
      send_xyz('0, '0, '0, 16'h0004);
      send_xyz(POS_MAX, '0, '0, 16'h0005);
      send_xyz($urandom, $urandom, $urandom, 16'h0006);

      // Plane x = 2.0, threshold 1.0: hit the threshold from both sides
      wait_drained();
      program_plane(Q_ONE, '0, '0, 32'hFFFE_0000, Q_ONE);
      send_xyz(32'h0003_0000, $urandom, $urandom, 16'h0007);
      send_xyz(32'h0001_0000, $urandom, $urandom, 16'h0008);
      send_xyz(32'h0002_8000, $urandom, $urandom, 16'h0009);
      send_xyz('0, $urandom, $urandom, 16'h000A);
      send_xyz(ALL_ONES, $urandom, $urandom, 16'h000B);

      // Odd fractions: truncation of negative products, smallest nonzero threshold
      wait_drained();
      program_plane(32'h0000_8001, 32'hFFFF_7FFF, 32'h0002_0000, 32'h0000_0001, 32'h0000_0001);
      send_xyz(ALL_ONES, 32'h0000_0001, 32'h0000_0003, 16'h000C);
      send_xyz(32'hFFFF_0000, Q_ONE, '0, 16'h000D);
      send_xyz('0, '0, '0, 16'h000E);
      send_xyz(near_value(), near_value(), near_value(), 16'h000F);
      send_xyz($urandom, $urandom, $urandom, 16'h0010);

      // Random phases, each under a fresh plane and its own traffic shape
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_drained();
         ready_pattern = (ph % 4 == 1) ? 16'hFFFF : (16'($urandom) | 16'h0001);
         if (ph == 4) hold_cycles = HOLD_OFF;
         random_plane(spread_kind'(ph % 3));
         if (ph == 4) begin
            // receiver held off: the pipe fills and request beats back up
            run_points(40, 1'b0);
            run_points(PHASE_POINTS - 40, 1'b1);
         end else if (ph == 5) begin
            run_points(PHASE_POINTS / 2, 1'b0);
            wait_drained();
            run_points(PHASE_POINTS - PHASE_POINTS / 2, 1'b0);
         end else begin
            run_points(PHASE_POINTS, ph % 4 != 1);
         end
      end

      wait_drained();
      repeat (3 * LATENCY) @(posedge clock);
      $display("Scored %0d points under %0d plane settings with bursty, stalled and held-off traffic.",
               points_sent, planes_set + 1);
      $display("Checked %0d responses: %0d inliers, %0d outliers, %0d failures.",
               ledger.checked, ledger.inliers, ledger.outliers, ledger.failures);
      if (ledger.failures == 0 && ledger.pending() == 0) begin
         $display("** point_plane_distance_project: PASSED **");
      end else begin
         $display("** point_plane_distance_project: FAILED **");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(WATCHDOG);
      $display("Timed out with %0d scores pending.", ledger.pending());
      $display("** point_plane_distance_project: FAILED **");
      $finish;
   end

endmodule

// ===== point_plane_distance_project.f =====
rtl/core/ppd_pkg.sv
rtl/core/ppd_csr.sv
rtl/core/ppd_score.sv
rtl/core/ppd_project.sv
rtl/core/point_plane_distance_project.sv
dv/tb.sv
